### design/ptm_pkg.sv
// Shared codes and field widths for the page type map allocator.
// No dependencies; used by the top level, the row store, the checker and the testbench.
package ptm_pkg;

    // Field widths
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned CFG_W  = 17;

    // Reset value of the page count register
    localparam logic [CFG_W-1:0] PAGE_COUNT_RESET = 17'h10000;

    // Operation codes (s_tuser)
    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Result status codes (m_tuser)
    localparam logic [1:0] ST_MARKED   = 2'd0;
    localparam logic [1:0] ST_GRANTED  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    // Page type codes
    localparam logic [1:0] PT_FREE      = 2'd0;
    localparam logic [1:0] PT_ALLOCATED = 2'd2;

    // Row content after reset: four reserved pages
    localparam logic [7:0] ROW_RESERVED = 8'hFF;

endpackage

### design/page_type_map_first_fit_allocator.sv
// Page type map with a first-fit allocator. Top level; depends on ptm_pkg and ptm_row_store.
// Holds a 2-bit type per page in a row memory of four pages per byte.
//
// One request at a time. A request is taken and set up, then walks the map one page per
// cycle through a single page compare/update unit, with read, latch and write back steps
// for each memory row touched, and then the result is posted. An allocation that succeeds
// walks the search span and then the granted run again to mark it. After reset the block
// clears the map one row per cycle and takes no request meanwhile; configuration writes
// are taken at any time. PAGE_BYTES must be a power of two.
module page_type_map_first_fit_allocator #(
    parameter int unsigned MAP_PAGES  = 65536,
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // request: tdata = start_address[31:0], byte_length[63:32], page_type[65:64], pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [0:0]  s_tuser,    // operation[0]
    // result: tdata = granted_address[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,    // status[1:0]
    // page count register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam int unsigned PB_SHIFT = $clog2(PAGE_BYTES);
    localparam int unsigned ROWS     = (MAP_PAGES + 3) / 4;
    localparam int unsigned ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned PW       = $clog2(MAP_PAGES + 1);
    localparam int unsigned LW       = (PW > ptm_pkg::CFG_W) ? PW : ptm_pkg::CFG_W;
    localparam int unsigned WW       = 34;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_LATCH  = 3'd4;
    localparam logic [2:0] S_PAGE   = 3'd5;
    localparam logic [2:0] S_STORE  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    // Control state
    logic [2:0]  state_reg, state_next;
    logic        alloc_reg, alloc_next;       // searching for a free run
    logic        dirty_reg, dirty_next;
    logic        last_reg, last_next;         // walk ends after this write back
    logic [1:0]  status_reg, status_next;
    logic [ptm_pkg::CFG_W-1:0] page_count_reg;
    logic        out_valid_reg, out_valid_next;

    // Request and walk payload
    logic [31:0]   addr_reg, addr_next;
    logic [31:0]   len_reg, len_next;
    logic [1:0]    ptype_reg, ptype_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] end_reg, end_next;
    logic [PW-1:0] run_start_reg, run_start_next;
    logic [PW-1:0] run_reg, run_next;
    logic [WW-1:0] need_reg, need_next;
    logic [7:0]    buf_reg, buf_next;
    logic [ROW_AW-1:0] wr_row_reg, wr_row_next;   // row held in buf_reg
    logic [31:0]   out_addr_reg, out_addr_next;
    logic [1:0]    out_status_reg, out_status_next;

    // Row store connections
    logic              wr_en;
    logic [7:0]        rd_data;
    logic              clear_busy;
    logic [ROW_AW-1:0] row_addr;

    // Setup arithmetic
    logic [PW-1:0]  lim;
    logic [WW-1:0]  lim_w;
    logic [WW-1:0]  first_w;
    logic [32:0]    last_sum;
    logic [WW-1:0]  end_w;
    logic [WW-1:0]  end_c;
    logic [WW-1:0]  need_w;
    logic [PW-1:0]  cur_inc;
    logic [1:0]     page_val;
    logic [2:0]     bit_lo;
    logic [PW+PB_SHIFT+31:0] grant_ext;

    // Clamp the page count to the map size
    always_comb
    begin
        if (LW'(page_count_reg) > LW'(MAP_PAGES))
        begin
            lim = PW'(MAP_PAGES);
        end
        else
        begin
            lim = PW'(page_count_reg);
        end
    end

    assign lim_w    = WW'(lim);
    assign first_w  = WW'(addr_reg >> PB_SHIFT);
    assign last_sum = {1'b0, addr_reg} + {1'b0, len_reg};
    assign end_w    = WW'(last_sum >> PB_SHIFT)
                      + WW'(|(last_sum & 33'(PAGE_BYTES - 1)));
    assign end_c    = (end_w > lim_w) ? lim_w : end_w;
    assign need_w   = WW'(len_reg >> PB_SHIFT)
                      + WW'(|(len_reg & 32'(PAGE_BYTES - 1)));

    assign cur_inc  = cur_reg + 1'b1;
    assign bit_lo   = {cur_reg[1:0], 1'b0};
    assign page_val = buf_reg[bit_lo +: 2];
    assign row_addr = cur_reg[ROW_AW+1:2];
    assign grant_ext = {32'd0, run_start_reg, PB_SHIFT'(0)};

    assign wr_en     = (state_reg == S_STORE) && dirty_reg;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Sequencer and shared page unit
    always_comb
    begin
        state_next      = state_reg;
        alloc_next      = alloc_reg;
        dirty_next      = dirty_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        ptype_next      = ptype_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        run_start_next  = run_start_reg;
        run_next        = run_reg;
        need_next       = need_reg;
        buf_next        = buf_reg;
        wr_row_next     = wr_row_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        // Drop the result once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                if (!clear_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next  = s_tdata[31:0];
                    len_next   = s_tdata[63:32];
                    ptype_next = s_tdata[65:64];
                    alloc_next = (s_tuser[0] == ptm_pkg::OP_ALLOC);
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                dirty_next = 1'b0;
                last_next  = 1'b0;
                cur_next   = PW'(first_w);
                run_next   = '0;
                need_next  = need_w;
                run_start_next = PW'(first_w);
                if (alloc_reg)
                begin
                    end_next = lim;
                    if ((need_w == '0) || (first_w >= lim_w))
                    begin
                        status_next = ptm_pkg::ST_NO_SPACE;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    end_next    = PW'(end_c);
                    status_next = ptm_pkg::ST_MARKED;
                    if (first_w >= end_c)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                // Remember the row being read for its write back
                wr_row_next = row_addr;
                state_next  = S_LATCH;
            end
            S_LATCH:
            begin
                buf_next   = rd_data;
                dirty_next = 1'b0;
                state_next = S_PAGE;
            end
            S_PAGE:
            begin
                cur_next = cur_inc;
                if (!alloc_reg)
                begin
                    // Write the type into this page
                    buf_next[bit_lo +: 2] = ptype_reg;
                    dirty_next = 1'b1;
                    if (cur_inc == end_reg)
                    begin
                        last_next  = 1'b1;
                        state_next = S_STORE;
                    end
                    else if (cur_inc[1:0] == 2'd0)
                    begin
                        state_next = S_STORE;
                    end
                end
                else if ((page_val == ptm_pkg::PT_FREE)
                         && ((WW'(run_reg) + 1'b1) == need_reg))
                begin
                    // Run found: walk it again and mark it allocated
                    alloc_next  = 1'b0;
                    ptype_next  = ptm_pkg::PT_ALLOCATED;
                    status_next = ptm_pkg::ST_GRANTED;
                    end_next    = cur_inc;
                    cur_next    = run_start_reg;
                    state_next  = S_STORE;
                end
                else
                begin
                    if (page_val == ptm_pkg::PT_FREE)
                    begin
                        run_next = run_reg + 1'b1;
                    end
                    else
                    begin
                        run_next       = '0;
                        run_start_next = cur_inc;
                    end
                    if (cur_inc == end_reg)
                    begin
                        status_next = ptm_pkg::ST_NO_SPACE;
                        state_next  = S_FINISH;
                    end
                    else if (cur_inc[1:0] == 2'd0)
                    begin
                        state_next = S_STORE;
                    end
                end
            end
            S_STORE:
            begin
                dirty_next = 1'b0;
                if (last_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_FINISH:
            begin
                // Post the result once the output slot is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_addr_next   = (status_reg == ptm_pkg::ST_GRANTED)
                                      ? grant_ext[31:0] : 32'd0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            alloc_reg      <= 1'b0;
            dirty_reg      <= 1'b0;
            last_reg       <= 1'b0;
            status_reg     <= ptm_pkg::ST_MARKED;
            out_valid_reg  <= 1'b0;
            page_count_reg <= ptm_pkg::PAGE_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            dirty_reg     <= dirty_next;
            last_reg      <= last_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                page_count_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        ptype_reg      <= ptype_next;
        cur_reg        <= cur_next;
        end_reg        <= end_next;
        run_start_reg  <= run_start_next;
        run_reg        <= run_next;
        need_reg       <= need_next;
        buf_reg        <= buf_next;
        wr_row_reg     <= wr_row_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    ptm_row_store #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW)
    ) u_row_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_row_reg),
        .wr_data    (buf_reg),
        .rd_addr    (row_addr),
        .rd_data    (rd_data),
        .clear_busy (clear_busy)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

endmodule

### design/ptm_row_store.sv
// Page map row memory: one byte per row, four 2-bit page types per row.
// Runs a clearing pass after reset that sets every row to reserved.
// Depends on ptm_pkg.
module ptm_row_store #(
    parameter int unsigned ROWS   = 16384,
    parameter int unsigned ROW_AW = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ROW_AW-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ROW_AW-1:0] rd_addr,
    output logic [7:0]        rd_data,
    output logic              clear_busy
);

    logic [7:0]        mem [ROWS];
    logic [ROW_AW-1:0] clr_idx_reg;
    logic [ROW_AW-1:0] clr_idx_next;
    logic              busy_reg;
    logic              busy_next;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_wa;
    logic [7:0]        mem_wd;

    // Advance the clearing sweep one row per cycle
    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            if (clr_idx_reg == ROW_AW'(ROWS - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    // Give the sweep the write port while it runs
    always_comb
    begin
        mem_we = wr_en;
        mem_wa = wr_addr;
        mem_wd = wr_data;
        if (busy_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
            mem_wd = ptm_pkg::ROW_RESERVED;
        end
    end

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[rd_addr];
    end

    assign clear_busy = busy_reg;

endmodule

### design/ptm_checker.sv
// Port-level checks for the page type map allocator, bound to its top level.
// Depends on ptm_pkg.
module ptm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Status is one of the three result codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ptm_pkg::ST_MARKED) || (m_tuser == ptm_pkg::ST_GRANTED)
                     || (m_tuser == ptm_pkg::ST_NO_SPACE))
        else $error("bad status code");

    // Address is zero unless an allocation was made
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ptm_pkg::ST_GRANTED) |-> (m_tdata == 32'd0))
        else $error("address on a result without a grant");

    // Busy right after taking a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule

bind page_type_map_first_fit_allocator ptm_checker u_ptm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/tb_page_type_map_first_fit_allocator.sv
// Self-checking testbench for page_type_map_first_fit_allocator.
// Depends on ptm_pkg and the top level; keeps its own copy of the page type map,
// predicts the reply to each mark or allocate request and checks every result.
module tb_page_type_map_first_fit_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes and widths taken from the package
    localparam int unsigned      CFG_W            = ptm_pkg::CFG_W;
    localparam logic [CFG_W-1:0] PAGE_COUNT_RESET = ptm_pkg::PAGE_COUNT_RESET;
    localparam logic             OP_MARK          = ptm_pkg::OP_MARK;
    localparam logic             OP_ALLOC         = ptm_pkg::OP_ALLOC;
    localparam logic [1:0]       ST_MARKED        = ptm_pkg::ST_MARKED;
    localparam logic [1:0]       ST_GRANTED       = ptm_pkg::ST_GRANTED;
    localparam logic [1:0]       ST_NO_SPACE      = ptm_pkg::ST_NO_SPACE;
    localparam logic [1:0]       PT_FREE          = ptm_pkg::PT_FREE;
    localparam logic [1:0]       PT_ALLOCATED     = ptm_pkg::PT_ALLOCATED;

    localparam int unsigned MAP_PAGES   = 65536;
    localparam int unsigned PAGE_BYTES  = 4096;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned IDLE_LIMIT  = 2000000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned RAND_PHASES = 6;
    localparam int unsigned PHASE_ITEMS = 300;

    // Page types the package leaves out
    localparam logic [1:0] PT_HOLE     = 2'd1;
    localparam logic [1:0] PT_RESERVED = 2'd3;

    typedef struct {
        logic        op;
        logic [31:0] start_address;
        logic [31:0] byte_length;
        logic [1:0]  page_type;
    } page_request_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] granted_address;
    } page_reply_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;   // start_address[31:0], byte_length[63:32], page_type[65:64]
    logic [0:0]  s_tuser   = '0;   // operation[0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // granted_address[31:0]
    logic [1:0]  m_tuser;          // status[1:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data  = '0;

    // Shadow state of the block
    logic [1:0]       page_types [MAP_PAGES];
    logic [CFG_W-1:0] page_count_shadow;
    page_reply_t      replies_due [$];
    page_reply_t      reply_head;

    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned rx_hold       = 0;
    int unsigned idle_cycles   = 0;
    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned marks_sent    = 0;
    int unsigned allocs_sent   = 0;
    int unsigned grants_due    = 0;
    int unsigned refusals_due  = 0;
    int unsigned count_writes  = 0;

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    page_type_map_first_fit_allocator #(
        .MAP_PAGES  (MAP_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic logic [31:0] page_addr(int unsigned page);
        return 32'(page) << PAGE_SHIFT;
    endfunction

    function automatic longint unsigned pages_in_use();
        longint unsigned lim;
        lim = page_count_shadow;
        return (lim > MAP_PAGES) ? MAP_PAGES : lim;
    endfunction

    // Write a type into pages [first, stop), skipping pages past the limit
    function automatic void fill_pages(longint unsigned first, longint unsigned stop,
                                       logic [1:0] kind);
        longint unsigned lim;
        lim = pages_in_use();
        if (stop > lim)
            stop = lim;
        for (longint unsigned p = first; p < stop; p++)
            page_types[p] = kind;
    endfunction

    // Apply one request to the shadow map and return the reply it causes
    function automatic page_reply_t predict_reply(page_request_t req);
        page_reply_t     rep;
        longint unsigned range_end;
        longint unsigned need;
        longint unsigned lim;
        longint unsigned run_start;
        longint unsigned run_len;
        logic [63:0]     byte_pos;
        rep.status          = ST_MARKED;
        rep.granted_address = '0;
        if (req.op == OP_MARK)
        begin
            // End of range is formed in 33 bits, rounded up to a page
            range_end = {32'd0, req.start_address} + {32'd0, req.byte_length};
            fill_pages(req.start_address >> PAGE_SHIFT,
                       (range_end + PAGE_BYTES - 1) >> PAGE_SHIFT, req.page_type);
        end
        else
        begin
            need      = ({32'd0, req.byte_length} + PAGE_BYTES - 1) >> PAGE_SHIFT;
            lim       = pages_in_use();
            run_start = req.start_address >> PAGE_SHIFT;
            run_len   = 0;
            rep.status = ST_NO_SPACE;
            // First fit: restart the run after every page that is not free
            if (need != 0)
            begin
                for (longint unsigned p = run_start; p < lim; p++)
                begin
                    if (page_types[p] == PT_FREE)
                    begin
                        run_len++;
                        if (run_len == need)
                        begin
                            fill_pages(run_start, run_start + need, PT_ALLOCATED);
                            byte_pos            = run_start * PAGE_BYTES;
                            rep.status          = ST_GRANTED;
                            rep.granted_address = byte_pos[31:0];
                            break;
                        end
                    end
                    else
                    begin
                        run_len   = 0;
                        run_start = p + 1;
                    end
                end
            end
        end
        return rep;
    endfunction

    function automatic page_request_t make_request(logic op, logic [31:0] addr,
                                                   logic [31:0] len, logic [1:0] kind);
        page_request_t req;
        req.op            = op;
        req.start_address = addr;
        req.byte_length   = len;
        req.page_type     = kind;
        return req;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap(bit enabled);
        int unsigned roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Random request: mostly frees and small allocations near the pages in use,
    // some other types, some full-width noise and some zero lengths
    function automatic page_request_t random_request(int unsigned lim);
        page_request_t req;
        int unsigned   roll;
        roll = $urandom_range(0, 99);
        req.op            = OP_MARK;
        req.page_type     = PT_FREE;
        req.start_address = page_addr($urandom_range(0, lim + 1));
        if ($urandom_range(0, 1) != 0)
            req.start_address = req.start_address | $urandom_range(0, PAGE_BYTES - 1);
        req.byte_length = $urandom_range(1, 8 * PAGE_BYTES);
        if (roll < 35)
        begin
            req.page_type = PT_FREE;
        end
        else if (roll < 47)
        begin
            req.page_type = 2'($urandom_range(1, 3));
        end
        else if (roll < 85)
        begin
            req.op        = OP_ALLOC;
            req.page_type = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1) != 0)
                req.start_address = $urandom_range(0, PAGE_BYTES - 1);
            req.byte_length = $urandom_range(1, 4 * PAGE_BYTES);
        end
        else if (roll < 95)
        begin
            req.op            = ($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_MARK;
            req.start_address = $urandom();
            if ($urandom_range(0, 1) != 0)
                req.start_address = $urandom_range(0, lim * PAGE_BYTES);
            req.byte_length = $urandom();
            req.page_type   = 2'($urandom_range(0, 3));
        end
        else
        begin
            req.op          = ($urandom_range(0, 1) != 0) ? OP_ALLOC : OP_MARK;
            req.page_type   = 2'($urandom_range(0, 3));
            req.byte_length = '0;
        end
        return req;
    endfunction

    // Drive one request and hold it until accepted
    task automatic send_request(input page_request_t req);
        page_reply_t rep;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, req.page_type, req.byte_length, req.start_address};
        s_tuser  <= req.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        rep = predict_reply(req);
        replies_due.push_back(rep);
        if (req.op == OP_MARK)
            marks_sent++;
        else
            allocs_sent++;
        if (rep.status == ST_GRANTED)
            grants_due++;
        if (rep.status == ST_NO_SPACE)
            refusals_due++;
    endtask

    // Drop valid for the given number of cycles
    task automatic pause_sender(input int unsigned cycles);
        if (cycles == 0)
            return;
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic issue_request(input page_request_t req);
        send_request(req);
        pause_sender(pick_gap(tx_idle_on));
    endtask

    // Hold off new requests until every outstanding reply has arrived
    task automatic wait_replies_done();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Write the page count register; only called while the block is idle
    task automatic write_page_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        page_count_shadow = value;
        count_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stall at random when enabled
    always @(negedge clk)
    begin
        if (rx_hold == 0)
            rx_hold = pick_gap(rx_idle_on);
        if (rx_hold != 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected reply
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (replies_due.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result status=%0d addr=0x%08h",
                                        m_tuser, m_tdata));
            end
            else
            begin
                reply_head = replies_due.pop_front();
                if (m_tuser !== reply_head.status)
                    note_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                            results_seen, reply_head.status, m_tuser));
                if (m_tdata !== reply_head.granted_address)
                    note_mismatch($sformatf("result %0d address: expected 0x%08h, got 0x%08h",
                                            results_seen, reply_head.granted_address,
                                            m_tdata));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d replies outstanding",
                     idle_cycles, replies_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Reset page count: the top of the full map, start beyond the map, zero length
    task automatic test_reset_page_count();
        issue_request(make_request(OP_MARK, page_addr(65532), 32'hFFFF_FFFF, PT_FREE));
        issue_request(make_request(OP_ALLOC, page_addr(65530), 2 * PAGE_BYTES, PT_FREE));
        issue_request(make_request(OP_ALLOC, page_addr(65535) + 1, 32'd1, PT_RESERVED));
        issue_request(make_request(OP_ALLOC, page_addr(65534), 2 * PAGE_BYTES, PT_FREE));
        issue_request(make_request(OP_ALLOC, page_addr(65534), 32'd0, PT_FREE));
        issue_request(make_request(OP_ALLOC, page_addr(65534), PAGE_BYTES, PT_HOLE));
        issue_request(make_request(OP_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PT_FREE));
        issue_request(make_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd1, PT_FREE));
    endtask

    // Pages in use: zero, partial rows, marks that skip and searches that stop at the limit
    task automatic test_map_limit();
        wait_replies_done();
        write_page_count('0);
        issue_request(make_request(OP_MARK, 32'd0, 32'hFFFF_FFFF, PT_FREE));
        issue_request(make_request(OP_ALLOC, 32'd0, 32'd1, PT_FREE));
        wait_replies_done();
        write_page_count(CFG_W'(12));
        issue_request(make_request(OP_MARK, 32'd0, 32'hFFFF_FFFF, PT_FREE));
        issue_request(make_request(OP_ALLOC, 32'd0, 12 * PAGE_BYTES, PT_FREE));
        issue_request(make_request(OP_ALLOC, 32'd0, 32'd1, PT_FREE));
        issue_request(make_request(OP_MARK, page_addr(8), 4 * PAGE_BYTES, PT_FREE));
        wait_replies_done();
        write_page_count(CFG_W'(10));
        issue_request(make_request(OP_ALLOC, page_addr(8), 3 * PAGE_BYTES, PT_FREE));
        issue_request(make_request(OP_MARK, page_addr(8), 8 * PAGE_BYTES, PT_HOLE));
        wait_replies_done();
        write_page_count(17'h1FFFF);
        issue_request(make_request(OP_ALLOC, page_addr(8), PAGE_BYTES, PT_FREE));
        issue_request(make_request(OP_ALLOC, page_addr(65535), 32'd1, PT_FREE));
        wait_replies_done();
        write_page_count(CFG_W'(16));
        issue_request(make_request(OP_ALLOC, page_addr(11), 5 * PAGE_BYTES, PT_FREE));
    endtask

    // Zero length marks, page crossing, every page type
    task automatic test_zero_length_and_types();
        wait_replies_done();
        write_page_count(CFG_W'(32));
        issue_request(make_request(OP_MARK, 32'd0, 32 * PAGE_BYTES, PT_FREE));
        issue_request(make_request(OP_MARK, page_addr(4), 32'd0, PT_RESERVED));
        issue_request(make_request(OP_MARK, page_addr(5) + 16, 32'd0, PT_HOLE));
        issue_request(make_request(OP_ALLOC, page_addr(4), 2 * PAGE_BYTES, PT_FREE));
        issue_request(make_request(OP_MARK, page_addr(9) + PAGE_BYTES - 1, 32'd2,
                                   PT_RESERVED));
        issue_request(make_request(OP_ALLOC, page_addr(8), 2 * PAGE_BYTES - 1, PT_FREE));
        issue_request(make_request(OP_MARK, page_addr(20), PAGE_BYTES, PT_ALLOCATED));
        issue_request(make_request(OP_ALLOC, page_addr(20), PAGE_BYTES, PT_FREE));
        issue_request(make_request(OP_MARK, 32'd0, 32'hFFFF_FFFF, PT_RESERVED));
        issue_request(make_request(OP_ALLOC, 32'd0, 32'd1, PT_FREE));
    endtask

    // Random traffic over several small map sizes with varying idle patterns
    task automatic test_random_traffic();
        int unsigned lim;
        for (int unsigned phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_replies_done();
            case (phase)
                0:       lim = 4;
                1:       lim = 1;
                default: lim = $urandom_range(5, 96);
            endcase
            write_page_count(CFG_W'(lim));
            tx_idle_on = (phase != 0);
            rx_idle_on = (phase != 0) && (phase != 4);
            // Open the whole map now and then so allocations find room
            if ($urandom_range(0, 1) != 0)
                issue_request(make_request(OP_MARK, 32'd0, 32'hFFFF_FFFF, PT_FREE));
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                // Let everything drain once mid-stream
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    wait_replies_done();
                issue_request(random_request(lim));
            end
        end
    endtask

    task automatic finish_run();
        wait_replies_done();
        repeat (64)
            @(posedge clk);
        $display("Checked %0d results: %0d marks, %0d allocations (%0d granted, %0d refused),",
                 results_seen, marks_sent, allocs_sent, grants_due, refusals_due);
        $display("across %0d page count settings; %0d mismatches.", count_writes, mismatches);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    endtask

    // Test sequence
    initial
    begin
        for (int unsigned p = 0; p < MAP_PAGES; p++)
            page_types[p] = PT_RESERVED;
        page_count_shadow = PAGE_COUNT_RESET;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_page_count();
        test_map_limit();
        test_zero_length_and_types();
        test_random_traffic();
        finish_run();
    end

endmodule

### page_type_map_first_fit_allocator.f
design/ptm_pkg.sv
design/ptm_row_store.sv
design/page_type_map_first_fit_allocator.sv
design/ptm_checker.sv
dv/tb_page_type_map_first_fit_allocator.sv
